### hdl/oist_pkg.sv
package oist_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_NEG    = 3'd1;
    localparam logic [2:0] ST_DUP    = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_ABSENT = 3'd4;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic       member;
        logic [4:0] count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic execute;
    } t_dp_cmd;

endpackage

### hdl/oist_ctrl.sv
module oist_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output oist_pkg::t_dp_cmd o_cmd
);
    import oist_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXE  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   fire;
    logic   take;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = (r_state == S_EXE) && out_free;
    assign o_in_ready = (r_state == S_IDLE) || fire;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXE;
            end
            S_EXE: begin
                if (fire) begin
                    n_state = take ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cmd.load    = take;
    assign o_cmd.compare = (r_state == S_CMP);
    assign o_cmd.execute = fire;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");

endmodule

### hdl/oist_dp.sv
module oist_dp #(
    parameter int CAPACITY = oist_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oist_pkg::t_dp_cmd   i_cmd,
    input  oist_pkg::t_in_item  i_in_data,
    output oist_pkg::t_out_item o_out_data
);
    import oist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]          r_func;
    logic [30:0]         r_key;
    logic                r_neg;
    logic [30:0]         r_entries [CAPACITY];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CAPACITY-1:0] r_hit;
    logic [CAPACITY-1:0] n_hit;
    logic [CAPACITY-1:0] first;
    logic [CAPACITY-1:0] upper;
    logic                found;
    logic                full;
    logic                do_insert;
    logic                do_remove;
    logic [2:0]          status;
    t_out_item           r_out;

    // Match of every live slot against the key; negative keys never match.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_hit[i] = !r_neg && (CW'(i) < r_count) && (r_entries[i] == r_key);
        end
    end

    assign found = |r_hit;
    assign first = r_hit & (~r_hit + 1'b1);
    // Slots at and above the match move down on a remove.
    assign upper = ~(first - 1'b1);
    assign full  = (r_count == CW'(CAPACITY));

    always_comb begin
        do_insert = 1'b0;
        do_remove = 1'b0;
        n_count   = r_count;
        case (r_func)
            FUNC_INSERT: begin
                if (r_neg) begin
                    status = ST_NEG;
                end else if (found) begin
                    status = ST_DUP;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    status    = ST_DONE;
                    do_insert = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (found) begin
                    status    = ST_DONE;
                    do_remove = 1'b1;
                    n_count   = r_count - 1'b1;
                end else begin
                    status = ST_ABSENT;
                end
            end
            default: begin
                status = found ? ST_DONE : ST_ABSENT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_data.func;
            r_key  <= i_in_data.value[30:0];
            r_neg  <= i_in_data.value[31];
        end
        if (i_cmd.execute) begin
            r_out.status <= status;
            r_out.member <= found;
            r_out.count  <= 5'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= '0;
            r_count <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= '0;
            end
        end else begin
            if (i_cmd.compare) begin
                r_hit <= n_hit;
            end
            if (i_cmd.execute) begin
                r_count <= n_count;
                // Slots above the count hold zero; the top slot shifts in a zero.
                for (int i = 0; i < CAPACITY; i++) begin
                    if (do_insert && (CW'(i) == r_count)) begin
                        r_entries[i] <= r_key;
                    end else if (do_remove && upper[i]) begin
                        r_entries[i] <= (i + 1 < CAPACITY) ? r_entries[(i + 1) % CAPACITY]
                                                           : '0;
                    end
                end
            end
        end
    end

    assign o_out_data = r_out;

    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_hit))
        else $error("stored value matched in more than one slot");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
                            || r_count == $past(r_count) + 1'b1
                            || r_count + 1'b1 == $past(r_count)))
        else $error("stored count moved by more than one");

endmodule

### hdl/ordered_integer_set_table.sv
// Ordered set of distinct non-negative 32-bit integers kept in insertion order in
// CAPACITY register slots. Each input beat asks to insert (func 0), remove (func 1)
// or look up (func 2 or 3) a value and yields exactly one output beat with a status
// (0 done, 1 negative refused, 2 already present, 3 table full, 4 not present), a
// flag telling whether the value was stored before the beat, and the count after it
// (modulo 32). A remove closes the gap by moving later entries down one slot. The
// store is empty after reset. A compare step matches the key against every slot and
// registers the match vector; an execute step, held while an untaken result waits,
// updates the slots and loads the output register. A new beat is taken as the execute
// step fires, and also while the previous result waits in the output register.
module ordered_integer_set_table #(
    parameter int CAPACITY = oist_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  oist_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output oist_pkg::t_out_item o_out_data
);
    import oist_pkg::*;

    t_dp_cmd cmd;

    oist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    oist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
